### src/adu_pkg.sv
// ----------------------------------------------------------------------------
// Adam update package
// Shared constants, register indexes and the control types of the
// iterative divide and square-root unit.
// ----------------------------------------------------------------------------
package adu_pkg;

  localparam int unsigned NUM_W = 88;
  localparam int unsigned DEN_W = 49;
  localparam int unsigned QUO_W = 64;
  localparam int unsigned CNT_W = 7;

  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic [23:0] HALF_Q24 = 24'd8388608;

  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_EPSILON       = 2'd1;
  localparam logic [1:0] REG_BETA_FIRST    = 2'd2;
  localparam logic [1:0] REG_BETA_SECOND   = 2'd3;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } unit_mode_t;

  typedef struct packed {
    logic             start;
    unit_mode_t       mode;
    logic [CNT_W-1:0] count;
  } unit_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_stat_t;

endpackage

### src/adam_parameter_update.sv
// ----------------------------------------------------------------------------
// Adam parameter update
// Fixed-point Adam step for one parameter per word, with a moment store.
// ----------------------------------------------------------------------------
// Usage: raise start with a word on the in_ ports while busy is low; the
// word is taken at that edge and busy stays high until its result is out.
// The result appears on the out_ ports for exactly one cycle with out_valid.
// Each word is first worked on the shared multiplier and the moment update,
// then by a division, a second division, a square root and a last division
// on the shared bit-serial unit. A word whose square root and epsilon are
// both zero skips the last division. A new word is not taken before its
// predecessor's result is shown; it may start in the cycle that result is
// shown. The receiver cannot stall. After reset the moment store is cleared
// one entry per cycle with busy high; configuration writes on the cfg_ port
// are taken at any time and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module adam_parameter_update import adu_pkg::*; #(
  parameter int PARAM_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_param_index,
  input  logic [31:0] in_param_value,
  input  logic [31:0] in_gradient,
  input  logic        in_step_end,
  output logic        out_valid,
  output logic [9:0]  out_index,
  output logic [31:0] out_new_value,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int XW = (AW > 10) ? AW : 10;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_PW2, S_M1, S_M2, S_G2, S_V1, S_V2, S_V3, S_V4, S_V5,
    S_DM, S_DV, S_SQ, S_T1, S_T2, S_T3, S_DS
  } state_t;

  state_t state_r;

  logic [23:0] lr_r;
  logic [31:0] eps_r;
  logic [23:0] b1_r;
  logic [23:0] b2_r;
  logic [24:0] bp1_r;
  logic [24:0] bp2_r;

  logic [9:0]         idx_r;
  logic               idx_ok_r;
  logic signed [31:0] pv_r;
  logic signed [31:0] g_r;
  logic               end_r;
  logic signed [31:0] m_r;
  logic [47:0]        v_r;
  logic [24:0]        pw1_r;
  logic [24:0]        pw2_r;
  logic signed [65:0] acc_r;
  logic [46:0]        g2_r;
  logic [49:0]        a_r;
  logic [49:0]        b_r;
  logic [55:0]        mh_r;
  logic [48:0]        den_r;
  logic [55:0]        t_r;

  logic               out_valid_r;
  logic [9:0]         out_index_r;
  logic [31:0]        out_new_value_r;
  logic               out_saturated_r;

  logic               clearing;
  logic [79:0]        rdata_r;
  logic               accept;
  logic               mem_we;
  logic [79:0]        mem_wdata;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [XW-1:0]      idx_in_x;
  logic [XW-1:0]      idx_x;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_r;

  unit_cmd_t          ucmd;
  unit_stat_t         ust;
  logic [NUM_W-1:0]   unum;
  logic [DEN_W-1:0]   uden;
  logic [QUO_W-1:0]   uq_r;

  logic [24:0]        c1;
  logic [24:0]        c2;
  logic [24:0]        d1;
  logic [24:0]        d2;
  logic [31:0]        ag;
  logic [31:0]        am;
  logic signed [65:0] m_sum;
  logic signed [65:0] m_full;
  logic signed [31:0] m_new;
  logic [50:0]        b_sum;
  logic [50:0]        v_full;
  logic [47:0]        v_new;
  logic [49:0]        pw_now;
  logic [24:0]        pw_rnd;
  logic [55:0]        t_now;
  logic [63:0]        vh_cap;
  logic [33:0]        step_cap;
  logic [33:0]        fin_step;
  logic signed [35:0] nv_full;
  logic [31:0]        nv;
  logic               nv_sat;

  assign accept   = start && !busy;
  assign busy     = clearing || (state_r != S_IDLE);
  assign idx_in_x = XW'(in_param_index);
  assign idx_x    = XW'(idx_r);
  assign rd_addr  = idx_in_x[AW-1:0];
  assign wr_addr  = idx_x[AW-1:0];

  always_comb begin
    c1     = ONE_Q24 - {1'b0, b1_r};
    c2     = ONE_Q24 - {1'b0, b2_r};
    d1     = ONE_Q24 - pw1_r;
    d2     = ONE_Q24 - pw2_r;
    ag     = g_r[31] ? (~g_r + 32'd1) : g_r;
    am     = m_r[31] ? (~m_r + 32'd1) : m_r;
    pw_now = prod_r[49:0] + 50'(HALF_Q24);
    pw_rnd = pw_now[48:24];
    m_sum  = acc_r + prod_r + 66'(HALF_Q24);
    m_full = m_sum >>> 24;
    if (m_full > 66'sd2147483647) begin
      m_new = 32'sh7fffffff;
    end else if (m_full < -66'sd2147483648) begin
      m_new = 32'sh80000000;
    end else begin
      m_new = m_full[31:0];
    end
    b_sum  = {1'b0, b_r} + 51'(prod_r[49:0]) + 51'(HALF_Q24);
    v_full = {1'b0, a_r} + 51'(b_sum[50:24]);
    v_new  = (v_full > 51'h0ffffffffffff) ? 48'hffffffffffff : v_full[47:0];
    t_now  = t_r + 56'(prod_r[55:24]);
    if (ust.ovf || (uq_r > 64'h4000000000000000)) begin
      vh_cap = 64'h4000000000000000;
    end else begin
      vh_cap = uq_r;
    end
    if (ust.ovf || (uq_r > 64'h0000000200000000)) begin
      step_cap = 34'h200000000;
    end else begin
      step_cap = uq_r[33:0];
    end
    fin_step = (state_r == S_DS) ? step_cap : 34'd0;
    if (m_r[31]) begin
      nv_full = 36'(pv_r) + $signed({2'b00, fin_step});
    end else begin
      nv_full = 36'(pv_r) - $signed({2'b00, fin_step});
    end
    nv_sat = 1'b0;
    if (!idx_ok_r) begin
      nv = pv_r;
    end else if (nv_full > 36'sd2147483647) begin
      nv     = 32'h7fffffff;
      nv_sat = 1'b1;
    end else if (nv_full < -36'sd2147483648) begin
      nv     = 32'h80000000;
      nv_sat = 1'b1;
    end else begin
      nv = nv_full[31:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LOAD: begin
        mul_a = $signed({8'b0, bp1_r});
        mul_b = $signed({9'b0, b1_r});
      end
      S_PW2: begin
        mul_a = $signed({8'b0, bp2_r});
        mul_b = $signed({9'b0, b2_r});
      end
      S_M1: begin
        mul_a = $signed({9'b0, b1_r});
        mul_b = $signed({m_r[31], m_r});
      end
      S_M2: begin
        mul_a = $signed({8'b0, c1});
        mul_b = $signed({g_r[31], g_r});
      end
      S_G2: begin
        mul_a = $signed({1'b0, ag});
        mul_b = $signed({1'b0, ag});
      end
      S_V1: begin
        mul_a = $signed({9'b0, b2_r});
        mul_b = $signed({9'b0, v_r[47:24]});
      end
      S_V2: begin
        mul_a = $signed({8'b0, c2});
        mul_b = $signed({10'b0, g2_r[46:24]});
      end
      S_V3: begin
        mul_a = $signed({9'b0, b2_r});
        mul_b = $signed({9'b0, v_r[23:0]});
      end
      S_V4: begin
        mul_a = $signed({8'b0, c2});
        mul_b = $signed({9'b0, g2_r[23:0]});
      end
      S_T1: begin
        mul_a = $signed({9'b0, lr_r});
        mul_b = $signed({1'b0, mh_r[55:24]});
      end
      S_T2: begin
        mul_a = $signed({9'b0, lr_r});
        mul_b = $signed({9'b0, mh_r[23:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ucmd.start = 1'b0;
    ucmd.mode  = MODE_DIV;
    ucmd.count = '0;
    unum       = '0;
    uden       = '0;
    unique case (state_r)
      S_V5: begin
        ucmd.start = 1'b1;
        ucmd.count = CNT_W'(56);
        unum       = {am, 56'b0};
        uden       = DEN_W'(d1);
      end
      S_DM: begin
        ucmd.start = ust.done;
        ucmd.count = CNT_W'(72);
        unum       = {v_r, 40'b0};
        uden       = DEN_W'(d2);
      end
      S_DV: begin
        ucmd.start = ust.done;
        ucmd.mode  = MODE_SQRT;
        ucmd.count = CNT_W'(48);
        unum       = {vh_cap, 24'b0};
      end
      S_T3: begin
        ucmd.start = (den_r != '0);
        ucmd.count = CNT_W'(88);
        unum       = {t_now, 32'b0};
        uden       = den_r;
      end
      default: begin
        ucmd.start = 1'b0;
      end
    endcase
  end

  assign mem_we    = (state_r == S_V5) && idx_ok_r;
  assign mem_wdata = {m_r, v_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= 24'd16777;
      eps_r <= 32'd43;
      b1_r  <= 24'd15099494;
      b2_r  <= 24'd16760438;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: lr_r  <= cfg_data[23:0];
        REG_EPSILON:       eps_r <= cfg_data;
        REG_BETA_FIRST:    b1_r  <= cfg_data[23:0];
        REG_BETA_SECOND:   b2_r  <= cfg_data[23:0];
        default:           lr_r  <= lr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bp1_r       <= ONE_Q24;
      bp2_r       <= ONE_Q24;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r    <= in_param_index;
            idx_ok_r <= (32'(in_param_index) < PARAM_DEPTH);
            pv_r     <= in_param_value;
            g_r      <= in_gradient;
            end_r    <= in_step_end;
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          m_r     <= rdata_r[79:48];
          v_r     <= rdata_r[47:0];
          state_r <= S_PW2;
        end
        S_PW2: begin
          pw1_r   <= pw_rnd;
          state_r <= S_M1;
        end
        S_M1: begin
          pw2_r   <= pw_rnd;
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r   <= prod_r;
          state_r <= S_G2;
        end
        S_G2: begin
          m_r     <= m_new;
          state_r <= S_V1;
        end
        S_V1: begin
          g2_r    <= prod_r[62:16];
          state_r <= S_V2;
        end
        S_V2: begin
          a_r     <= prod_r[49:0];
          state_r <= S_V3;
        end
        S_V3: begin
          a_r     <= a_r + prod_r[49:0];
          state_r <= S_V4;
        end
        S_V4: begin
          b_r     <= prod_r[49:0];
          state_r <= S_V5;
        end
        S_V5: begin
          v_r     <= v_new;
          state_r <= S_DM;
        end
        S_DM: begin
          if (ust.done) begin
            mh_r    <= uq_r[55:0];
            state_r <= S_DV;
          end
        end
        S_DV: begin
          if (ust.done) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (ust.done) begin
            den_r   <= {1'b0, uq_r[47:0]} + DEN_W'(eps_r);
            state_r <= S_T1;
          end
        end
        S_T1: begin
          state_r <= S_T2;
        end
        S_T2: begin
          t_r     <= prod_r[55:0];
          state_r <= S_T3;
        end
        S_T3, S_DS: begin
          if ((state_r == S_DS && ust.done) || (state_r == S_T3 && den_r == '0)) begin
            out_valid_r     <= 1'b1;
            out_index_r     <= idx_r;
            out_new_value_r <= nv;
            out_saturated_r <= nv_sat;
            if (end_r) begin
              bp1_r <= pw1_r;
              bp2_r <= pw2_r;
            end
            state_r <= S_IDLE;
          end else if (state_r == S_T3) begin
            state_r <= S_DS;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  adu_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  adu_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ucmd),
    .num   (unum),
    .den   (uden),
    .q_r   (uq_r),
    .stat  (ust)
  );

  adu_mstore #(
    .DEPTH (PARAM_DEPTH),
    .AW    (AW)
  ) u_mstore (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rdata_r  (rdata_r),
    .wr_en    (mem_we),
    .wr_addr  (wr_addr),
    .wdata    (mem_wdata),
    .clearing (clearing)
  );

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_new_value = out_new_value_r;
  assign out_saturated = out_saturated_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy) else $error("word accepted during clearing pass");
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bp1_r <= ONE_Q24) && (bp2_r <= ONE_Q24)) else $error("beta power above one");
  a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    ust.done |-> (state_r == S_DM || state_r == S_DV || state_r == S_SQ ||
                  state_r == S_DS)) else $error("unit finished outside a wait state");
`endif

endmodule

### src/adu_mul.sv
// ----------------------------------------------------------------------------
// Adam update multiplier
// Shared signed 33 by 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module adu_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

### src/adu_divsqrt.sv
// ----------------------------------------------------------------------------
// Adam update divide and square-root unit
// One bit per cycle restoring division or digit-by-digit square root,
// both built around one shared subtractor.
// ----------------------------------------------------------------------------
module adu_divsqrt import adu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  unit_cmd_t        cmd,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] q_r,
  output unit_stat_t       stat
);

  logic             busy_r;
  logic             done_r;
  logic             ovf_r;
  unit_mode_t       mode_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] sr_r;
  logic [DEN_W-1:0] den_r;
  logic [49:0]      rem_r;
  logic [51:0]      op_a;
  logic [51:0]      op_b;
  logic [52:0]      diff;
  logic             ge;

  always_comb begin
    unique case (mode_r)
      MODE_DIV: begin
        op_a = {1'b0, rem_r, sr_r[NUM_W-1]};
        op_b = {3'b000, den_r};
      end
      MODE_SQRT: begin
        op_a = {rem_r, sr_r[NUM_W-1 -: 2]};
        op_b = {q_r[49:0], 2'b01};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[52];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        mode_r <= cmd.mode;
        cnt_r  <= cmd.count;
        sr_r   <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[49:0] : op_a[49:0];
        q_r   <= {q_r[QUO_W-2:0], ge};
        if (mode_r == MODE_DIV) begin
          ovf_r <= ovf_r | q_r[QUO_W-1];
          sr_r  <= {sr_r[NUM_W-2:0], 1'b0};
        end else begin
          sr_r <= {sr_r[NUM_W-3:0], 2'b00};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

### src/adu_mstore.sv
// ----------------------------------------------------------------------------
// Adam update moment store
// Holds the first and second moment of every parameter in one memory,
// with a clearing pass after reset.
// ----------------------------------------------------------------------------
module adu_mstore #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [79:0]   rdata_r,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [79:0]   wdata,
  output logic          clearing
);

  logic [79:0]   mem [DEPTH];
  logic          clear_r;
  logic [AW-1:0] ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r <= 1'b1;
      ptr_r   <= '0;
    end else if (clear_r) begin
      ptr_r <= ptr_r + 1'b1;
      if (ptr_r == AW'(DEPTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_r) begin
      mem[ptr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign clearing = clear_r;

endmodule
